>>> rtl/core/access_heat_counter_decay_defines.svh
// ---------------------------------------------------------------------------
// Access heat counter - assertion macros
// Clocked assertion helpers; they expect clk and rst_n in scope and expand
// to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef ACCESS_HEAT_COUNTER_DECAY_DEFINES_SVH
`define ACCESS_HEAT_COUNTER_DECAY_DEFINES_SVH

`ifndef SYNTHESIS
`define AHC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ahc assertion failed");
`define AHC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ahc assertion failed");
`else
`define AHC_ASSERT_NOW(lbl, ante, cons)
`define AHC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/ahc_pkg.sv
// ---------------------------------------------------------------------------
// Access heat counter - package
// Mode codes, write source codes, controller/datapath structs and the decay
// function shared by the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ahc_pkg;

    localparam logic [1:0] MODE_ACCESS = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_DECAY  = 2'd2;

    localparam logic [1:0] WR_ITEM  = 2'd0;
    localparam logic [1:0] WR_DECAY = 2'd1;
    localparam logic [1:0] WR_ZERO  = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       rd_en;
        logic       rd_sweep;
        logic       wr_en;
        logic [1:0] wr_src;
        logic       sweep_clear;
        logic       sweep_step;
        logic       out_load;
    } ahc_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic out_free;
    } ahc_status_t;

    // v - ceil(v/16)
    function automatic logic [31:0] decayed(input logic [31:0] v);
        logic [31:0] cut;
        cut = {4'd0, v[31:4]} + {31'd0, |v[3:0]};
        return v - cut;
    endfunction

endpackage

>>> rtl/core/ahc_ctrl.sv
// ---------------------------------------------------------------------------
// Access heat counter - controller
// Sequences the clearing pass, access/query read-modify-write, decay sweep
// and result hand-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "access_heat_counter_decay_defines.svh"

module ahc_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           mode,
    output logic                 in_ready,
    input  ahc_pkg::ahc_status_t status,
    output ahc_pkg::ahc_cmd_t    cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_DRD   = 3'd3;
    localparam logic [2:0] S_DWR   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       in_fire;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.wr_src = ahc_pkg::WR_ITEM;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = ahc_pkg::WR_ZERO;
                if (status.sweep_last)
                begin
                    cmd.sweep_clear = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.sweep_step = 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    cmd.rd_en   = 1'b1;
                    state_next  = (mode == ahc_pkg::MODE_DECAY) ? S_DRD : S_EXEC;
                end
            end
            S_EXEC:
            begin
                // write back and present the result together, once
                if (status.out_free)
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DRD:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_sweep = 1'b1;
                state_next   = S_DWR;
            end
            S_DWR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = ahc_pkg::WR_DECAY;
                if (status.sweep_last)
                begin
                    cmd.sweep_clear = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.sweep_step = 1'b1;
                    state_next     = S_DRD;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `AHC_ASSERT_NEXT(a_item_to_exec, in_fire && mode != ahc_pkg::MODE_DECAY, state_reg == S_EXEC)
    `AHC_ASSERT_NEXT(a_decay_to_sweep, in_fire && mode == ahc_pkg::MODE_DECAY, state_reg == S_DRD)
    `AHC_ASSERT_NOW(a_no_result_overrun, cmd.out_load, status.out_free)
    `AHC_ASSERT_NOW(a_write_follows_read, state_reg == S_DWR, $past(state_reg) == S_DRD)

endmodule

>>> rtl/core/ahc_datapath.sv
// ---------------------------------------------------------------------------
// Access heat counter - datapath
// Counter store (one row of kind counters per address), item registers,
// sweep counter, increment/decay logic and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ahc_datapath
#(
    parameter int ADDR_SPACE = 65536,
    parameter int KIND_COUNT = 3
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ahc_pkg::ahc_cmd_t    cmd,
    output ahc_pkg::ahc_status_t status,
    input  logic [1:0]           mode,
    input  logic [1:0]           access_kind,
    input  logic [15:0]          address,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [31:0]          count
);

    localparam int AW  = $clog2(ADDR_SPACE);
    localparam int KIW = (KIND_COUNT > 1) ? $clog2(KIND_COUNT) : 1;

    typedef logic [KIND_COUNT-1:0][31:0] row_t;

    row_t        mem [ADDR_SPACE];
    row_t        rdata_reg;
    row_t        wdata;
    row_t        item_row;
    row_t        decay_row;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_do;

    logic [1:0]    mode_reg;
    logic [1:0]    kind_reg;
    logic [15:0]   addr_reg;
    logic [AW-1:0] sweep_reg;
    logic [AW-1:0] sweep_next;
    logic          out_valid_reg;
    logic [31:0]   count_reg;

    logic          in_range;
    logic [KIW-1:0] kind_idx;
    logic [31:0]   cur;
    logic [31:0]   inc;
    logic [31:0]   result;

    assign kind_idx = kind_reg[KIW-1:0];
    assign in_range = ({1'b0, kind_reg} < 3'(KIND_COUNT))
                   && ({1'b0, addr_reg} < 17'(ADDR_SPACE));
    assign cur      = rdata_reg[kind_idx];
    assign inc      = (cur == 32'hFFFF_FFFF) ? cur : cur + 32'd1;

    always_comb
    begin
        item_row           = rdata_reg;
        item_row[kind_idx] = inc;
        for (int k = 0; k < KIND_COUNT; k++)
        begin
            decay_row[k] = ahc_pkg::decayed(rdata_reg[k]);
        end
    end

    always_comb
    begin
        result = 32'd0;
        if (in_range && mode_reg == ahc_pkg::MODE_ACCESS)
        begin
            result = inc;
        end
        else if (in_range && mode_reg == ahc_pkg::MODE_QUERY)
        begin
            result = cur;
        end
    end

    always_comb
    begin
        case (cmd.wr_src)
            ahc_pkg::WR_DECAY: wdata = decay_row;
            ahc_pkg::WR_ZERO:  wdata = '0;
            default:           wdata = item_row;
        endcase
    end

    // item writes only for an in-range access
    assign wr_do   = cmd.wr_en && ((cmd.wr_src != ahc_pkg::WR_ITEM)
                   || (in_range && mode_reg == ahc_pkg::MODE_ACCESS));
    assign wr_addr = (cmd.wr_src == ahc_pkg::WR_ITEM) ? addr_reg[AW-1:0] : sweep_reg;
    assign rd_addr = cmd.rd_sweep ? sweep_reg : address[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_do)
        begin
            mem[wr_addr] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            kind_reg <= access_kind;
            addr_reg <= address;
        end
        if (cmd.out_load)
        begin
            count_reg <= result;
        end
    end

    always_comb
    begin
        sweep_next = sweep_reg;
        if (cmd.sweep_clear)
        begin
            sweep_next = '0;
        end
        else if (cmd.sweep_step)
        begin
            sweep_next = sweep_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sweep_reg <= sweep_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.sweep_last = (sweep_reg == AW'(ADDR_SPACE - 1));
    assign status.out_free   = !out_valid_reg || out_ready;
    assign out_valid         = out_valid_reg;
    assign count             = count_reg;

endmodule

>>> rtl/core/access_heat_counter_decay.sv
// ---------------------------------------------------------------------------
// Access heat counter with decay
// Per-address, per-kind saturating 32-bit access counters with a global
// decay sweep.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries mode, access_kind, address.
//   Output channel (out_valid/out_ready) returns one count per item.
//   Access increments the selected counter (saturating) and returns the new
//   value; query returns it; decay maps every v to v - ceil(v/16) and
//   returns zero. Out-of-range kind/address and the unused mode return zero.
//   Access and query do one store read, then the output load, with the
//   write-back for access only. Decay walks the store one address row
//   at a time, read then write.
//   After reset a clearing pass writes zero to every row, one row a cycle,
//   before in_ready rises.
//   The result sits in an output register; while the receiver stalls the
//   next item is still taken and its store read done, and the block holds
//   in its final step until the register frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module access_heat_counter_decay
#(
    parameter int ADDR_SPACE = 65536,
    parameter int KIND_COUNT = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [1:0]  access_kind,
    input  logic [15:0] address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] count
);

    ahc_pkg::ahc_cmd_t    cmd;
    ahc_pkg::ahc_status_t status;

    ahc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ahc_datapath
    #(
        .ADDR_SPACE (ADDR_SPACE),
        .KIND_COUNT (KIND_COUNT)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .mode        (mode),
        .access_kind (access_kind),
        .address     (address),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .count       (count)
    );

endmodule

>>> sim/tb_access_heat_counter_decay.sv
// ---------------------------------------------------------------------------
// Access heat counter - testbench
// Drives access, query, decay and unused-mode requests through the valid/
// ready input channel with bursty gaps, stalls the result channel on a
// changing pattern, and checks every returned count against a scoreboard
// model of the counter store.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_access_heat_counter_decay;

    localparam int          ADDR_SPACE   = 65536;
    localparam int          KIND_COUNT   = 3;
    localparam logic [1:0]  MODE_UNUSED  = 2'd3;
    localparam logic [1:0]  KIND_INVALID = 2'd3;
    localparam int          RANDOM_ITEMS = 1230;
    localparam int          DECAY_FIRST  = 400;
    localparam int          DECAY_SECOND = 850;
    // clearing pass plus one full decay sweep, taken several times over
    localparam int          IDLE_LIMIT   = 600000;
    localparam int          TAIL_CYCLES  = 20;

    typedef struct {
        logic [1:0]  mode;
        logic [1:0]  kind;
        logic [15:0] address;
        bit          drain;
    } heat_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  mode = ahc_pkg::MODE_ACCESS;
    logic [1:0]  access_kind = 2'd0;
    logic [15:0] address = 16'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] count;

    heat_req_t   pending_reqs[$];
    heat_req_t   drive_req;
    heat_req_t   seen_req;
    logic [31:0] expected_counts[$];
    logic [31:0] heat_count[int unsigned];
    logic [31:0] want;

    int          burst_left = 1;
    int          gap_left = 0;
    logic [7:0]  stall_phase = 8'd0;
    logic [1:0]  stall_style = 2'd0;

    int          outstanding = 0;
    int          sent_count = 0;
    int          idle_cycles = 0;
    int          fail_count = 0;
    int          total_items = 0;
    bit          timed_out = 1'b0;

    access_heat_counter_decay u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .access_kind (access_kind),
        .address     (address),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .count       (count)
    );

    always #1 clk = ~clk;

    // Apply one request to the counter model and return the count it yields.
    // Saturation is modelled but out of reach at this run length.
    function automatic logic [31:0] predict_count(heat_req_t req);
        int unsigned slot;
        bit          in_range;
        logic [31:0] v;
        logic [32:0] wide;
        predict_count = '0;
        in_range = (req.kind < KIND_COUNT) && (int'(req.address) < ADDR_SPACE);
        slot = int'(req.address) * KIND_COUNT + int'(req.kind);
        case (req.mode)
            ahc_pkg::MODE_ACCESS:
            begin
                if (in_range)
                begin
                    v = heat_count.exists(slot) ? heat_count[slot] : 32'd0;
                    if (v != 32'hFFFF_FFFF)
                        v = v + 32'd1;
                    heat_count[slot] = v;
                    predict_count = v;
                end
            end
            ahc_pkg::MODE_QUERY:
            begin
                if (in_range && heat_count.exists(slot))
                    predict_count = heat_count[slot];
            end
            ahc_pkg::MODE_DECAY:
            begin
                foreach (heat_count[k])
                begin
                    wide = {1'b0, heat_count[k]} + 33'd15;
                    heat_count[k] = heat_count[k] - 32'(wide >> 4);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void add_request(logic [1:0] m, logic [1:0] k, logic [15:0] a,
                                        bit drain);
        heat_req_t req;
        req.mode = m;
        req.kind = k;
        req.address = a;
        req.drain = drain;
        pending_reqs.push_back(req);
    endfunction

    // Mostly a handful of hot addresses so counters climb past the decay step.
    function automatic logic [15:0] pick_address();
        logic [15:0] a;
        if ($urandom_range(0, 4) == 0)
            a = 16'($urandom_range(0, 65535));
        else
        begin
            case ($urandom_range(0, 5))
                0: a = 16'h0000;
                1: a = 16'hFFFF;
                2: a = 16'h0001;
                3: a = 16'h8000;
                4: a = 16'h1234;
                default: a = 16'h00FF;
            endcase
        end
        return a;
    endfunction

    // Sender: bursts of random length, random gaps, optional drain before a request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            mode        <= ahc_pkg::MODE_ACCESS;
            access_kind <= 2'd0;
            address     <= 16'd0;
            burst_left  <= 1;
            gap_left    <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0
                     && (!pending_reqs[0].drain || (outstanding == 0 && !in_valid)))
            begin
                drive_req = pending_reqs.pop_front();
                in_valid    <= 1'b1;
                mode        <= drive_req.mode;
                access_kind <= drive_req.kind;
                address     <= drive_req.address;
                if (burst_left <= 1)
                begin
                    burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                              : $urandom_range(1, 8);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: switch stall style each time the 8-bit phase counter wraps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            stall_phase <= 8'd0;
            stall_style <= 2'd0;
        end
        else
        begin
            stall_phase <= stall_phase + 8'd1;
            if (stall_phase == 8'hFF)
                stall_style <= 2'($urandom_range(0, 3));
            case (stall_style)
                2'd0: out_ready <= 1'b1;
                2'd1: out_ready <= ($urandom_range(0, 3) != 0);
                2'd2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= stall_phase[2];
            endcase
        end
    end

    // Predict on each input transfer, check on each result transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding <= 0;
            sent_count  <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                seen_req.mode    = mode;
                seen_req.kind    = access_kind;
                seen_req.address = address;
                seen_req.drain   = 1'b0;
                expected_counts.push_back(predict_count(seen_req));
            end
            if (out_valid && out_ready)
            begin
                if (expected_counts.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("result %0d with no request outstanding", count);
                    fail_count++;
                end
                else
                begin
                    want = expected_counts.pop_front();
                    if (count !== want)
                    begin
                        if (fail_count < 10)
                            $display("count mismatch: expected %0d, got %0d", want, count);
                        fail_count++;
                    end
                end
            end
            outstanding <= outstanding + ((in_valid && in_ready) ? 1 : 0)
                           - ((out_valid && out_ready) ? 1 : 0);
            sent_count  <= sent_count + ((in_valid && in_ready) ? 1 : 0);
            idle_cycles <= ((in_valid && in_ready) || (out_valid && out_ready))
                           ? 0 : idle_cycles + 1;
        end
    end

    initial
    begin
        int          counted;
        int          roll;
        logic [1:0]  k;

        // directed: cleared store, increments, range edges, unused mode,
        // decay of small values, a count of one to zero
        add_request(ahc_pkg::MODE_QUERY,  2'd0, 16'h0000, 1'b0);
        add_request(ahc_pkg::MODE_ACCESS, 2'd0, 16'h0000, 1'b0);
        add_request(ahc_pkg::MODE_ACCESS, 2'd0, 16'h0000, 1'b0);
        add_request(ahc_pkg::MODE_ACCESS, 2'd0, 16'h0000, 1'b0);
        add_request(ahc_pkg::MODE_ACCESS, 2'd2, 16'hFFFF, 1'b0);
        add_request(ahc_pkg::MODE_ACCESS, KIND_INVALID, 16'hFFFF, 1'b0);
        add_request(ahc_pkg::MODE_QUERY,  KIND_INVALID, 16'hFFFF, 1'b0);
        add_request(MODE_UNUSED, 2'd0, 16'hFFFF, 1'b0);
        add_request(MODE_UNUSED, KIND_INVALID, 16'h0000, 1'b0);
        add_request(ahc_pkg::MODE_ACCESS, 2'd1, 16'h5AA5, 1'b0);
        add_request(ahc_pkg::MODE_ACCESS, 2'd1, 16'hA55A, 1'b0);
        add_request(ahc_pkg::MODE_QUERY,  2'd0, 16'h0000, 1'b0);
        add_request(ahc_pkg::MODE_QUERY,  2'd2, 16'hFFFF, 1'b0);
        add_request(ahc_pkg::MODE_QUERY,  2'd1, 16'h5AA5, 1'b0);
        add_request(ahc_pkg::MODE_DECAY,  2'd0, 16'h0000, 1'b1);
        add_request(ahc_pkg::MODE_QUERY,  2'd0, 16'h0000, 1'b0);
        add_request(ahc_pkg::MODE_QUERY,  2'd2, 16'hFFFF, 1'b0);
        add_request(ahc_pkg::MODE_QUERY,  2'd1, 16'hA55A, 1'b0);
        add_request(ahc_pkg::MODE_ACCESS, 2'd1, 16'h8000, 1'b0);
        add_request(ahc_pkg::MODE_QUERY,  2'd1, 16'h8000, 1'b0);

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if (counted == DECAY_FIRST || counted == DECAY_SECOND)
            begin
                add_request(ahc_pkg::MODE_DECAY, 2'($urandom_range(0, 3)),
                            16'($urandom_range(0, 65535)), counted == DECAY_FIRST);
            end
            else
            begin
                roll = $urandom_range(0, 99);
                k = ($urandom_range(0, 19) == 0) ? KIND_INVALID : 2'($urandom_range(0, 2));
                if (roll < 4)
                    add_request(MODE_UNUSED, 2'($urandom_range(0, 3)),
                                16'($urandom_range(0, 65535)), 1'b0);
                else
                    add_request((roll < 64) ? ahc_pkg::MODE_ACCESS : ahc_pkg::MODE_QUERY,
                                k, pick_address(), 1'b0);
            end
            counted++;
        end
        total_items = pending_reqs.size();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (!timed_out && !(sent_count == total_items && outstanding == 0))
        begin
            @(negedge clk);
            if (idle_cycles >= IDLE_LIMIT)
                timed_out = 1'b1;
        end

        if (timed_out)
            $display("Test completed with failures");
        else
        begin
            repeat (TAIL_CYCLES) @(negedge clk);
            if (expected_counts.size() != 0)
                fail_count++;
            if (fail_count == 0)
                $display("Test completed successfully");
            else
                $display("Test completed with failures");
        end
        $finish;
    end

endmodule
